[hw/rtl/pnss_pkg.sv]
// Shared types and constants for the position automaton set-step block.
`timescale 1ns / 1ps

package pnss_pkg;

    localparam int SET_W    = 32;
    localparam int SYM_W    = 8;
    localparam int IDX_W    = 5;
    localparam int FINAL_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        ACT_ADVANCE = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_ROW     = 2'd2,
        ACT_LABEL   = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL = 1'd1;

    // Empty label: low above high.
    localparam logic [SYM_W-1:0] LABEL_LO_RST = 8'hFF;
    localparam logic [SYM_W-1:0] LABEL_HI_RST = 8'h00;

    typedef struct packed {
        logic             row_we;
        logic             lbl_we;
        logic [IDX_W-1:0] addr;
        logic [SET_W-1:0] row;
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
    } t_tbl_wr;

    typedef struct packed {
        logic [SET_W-1:0] row;
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
    } t_tbl_rd;

endpackage

[hw/rtl/pnss_table.sv]
// Follow-row and label memories with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module pnss_table
    import pnss_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tbl_wr                    i_wr,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output t_tbl_rd                    o_rd
);

    localparam int AW = $clog2(DEPTH);

    logic [SET_W-1:0]   r_row_mem [DEPTH];
    logic [2*SYM_W-1:0] r_lbl_mem [DEPTH];
    logic [DEPTH-1:0]   r_row_vld;
    logic [DEPTH-1:0]   r_lbl_vld;

    logic [SET_W-1:0]   r_row_q;
    logic [2*SYM_W-1:0] r_lbl_q;
    logic               r_row_vq;
    logic               r_lbl_vq;

    logic [AW-1:0] w_waddr;
    assign w_waddr = i_wr.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.row_we) begin
            r_row_mem[w_waddr] <= i_wr.row;
        end
        if (i_wr.lbl_we) begin
            r_lbl_mem[w_waddr] <= {i_wr.hi, i_wr.lo};
        end
        r_row_q <= r_row_mem[i_raddr];
        r_lbl_q <= r_lbl_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_lbl_vld <= '0;
            r_row_vq  <= 1'b0;
            r_lbl_vq  <= 1'b0;
        end else begin
            if (i_wr.row_we) begin
                r_row_vld[w_waddr] <= 1'b1;
            end
            if (i_wr.lbl_we) begin
                r_lbl_vld[w_waddr] <= 1'b1;
            end
            r_row_vq <= r_row_vld[i_raddr];
            r_lbl_vq <= r_lbl_vld[i_raddr];
        end
    end

    // Entries never written read as their reset values.
    assign o_rd.row = r_row_vq ? r_row_q : '0;
    assign o_rd.lo  = r_lbl_vq ? r_lbl_q[SYM_W-1:0] : LABEL_LO_RST;
    assign o_rd.hi  = r_lbl_vq ? r_lbl_q[2*SYM_W-1:SYM_W] : LABEL_HI_RST;

endmodule

[hw/rtl/position_nfa_set_step.sv]
// Top level: position automaton NFA stepper over a bit set of active states.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s        | in  | i_s_tvalid/o_s_tready  | tuser: action; tdata: symbol .. label_high
//  m        | out | o_m_tvalid/i_m_tready  | tdata: accepting, is_stuck, active_set
//  cfg      | in  | i_cfg_we               | i_cfg_index, i_cfg_data
//
// An advance sweeps the single table read port one state per cycle, L = min(STATE_COUNT, 32)
// states; the scan state consumes the last registered read into the active set, and the
// done state loads the result once the output is free, raising o_s_tready again with it.
// Restart and table writes go straight to the done state, which loads their result likewise.
// Reset (synchronous, active low) empties the active set and marks all table rows
// unwritten. o_s_tready is low while an item is in work or its result waits to load.
`timescale 1ns / 1ps

module position_nfa_set_step
    import pnss_pkg::*;
#(
    parameter int STATE_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [60:53] label_high, [52:45] label_low, [44:13] row_bits,
    // [12:8] state_index, [7:0] symbol
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [33:2] active_set, [1] is_stuck, [0] accepting
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SET_W-1:0]      i_cfg_data
);

    localparam int LIVE  = (STATE_COUNT > SET_W) ? SET_W : STATE_COUNT;
    localparam int AW    = $clog2(LIVE);
    localparam int CNT_W = $clog2(LIVE + 1);
    localparam logic [SET_W-1:0] LIVE_MASK =
        (LIVE >= SET_W) ? '1 : ((SET_W'(1) << LIVE) - SET_W'(1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [SET_W-1:0]  r_active;
    logic [SET_W-1:0]  r_start;
    logic [FINAL_W-1:0] r_final;
    logic [SYM_W-1:0]  r_sym;
    logic [SET_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_v;
    logic [AW-1:0]     r_rd_q;
    logic              r_out_valid;
    logic              r_out_acc;
    logic              r_out_stuck;
    logic [SET_W-1:0]  r_out_set;

    // Input fields
    t_action           w_action;
    logic [SYM_W-1:0]  w_symbol;
    logic [IDX_W-1:0]  w_idx;
    logic [SET_W-1:0]  w_row;
    logic [SYM_W-1:0]  w_lo;
    logic [SYM_W-1:0]  w_hi;

    assign w_action = t_action'(i_s_tuser[1:0]);
    assign w_symbol = i_s_tdata[7:0];
    assign w_idx    = i_s_tdata[12:8];
    assign w_row    = i_s_tdata[44:13];
    assign w_lo     = i_s_tdata[52:45];
    assign w_hi     = i_s_tdata[60:53];

    logic w_accept;
    logic w_idx_ok;
    logic w_out_free;
    logic w_final_ok;
    logic w_hit;
    logic w_last;
    logic [SET_W-1:0] n_acc;
    t_tbl_wr w_wr;
    t_tbl_rd w_rd;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_idx_ok   = {1'b0, w_idx} < (IDX_W + 1)'(LIVE);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_final_ok = {1'b0, r_final} < (FINAL_W + 1)'(LIVE);

    always_comb begin
        w_wr.row_we = w_accept && (w_action == ACT_ROW) && w_idx_ok;
        w_wr.lbl_we = w_accept && (w_action == ACT_LABEL) && w_idx_ok;
        w_wr.addr   = w_idx;
        w_wr.row    = w_row & LIVE_MASK;
        w_wr.lo     = w_lo;
        w_wr.hi     = w_hi;
    end

    pnss_table #(
        .DEPTH (LIVE)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rd    (w_rd)
    );

    // Shared compare unit: one state per cycle against the held symbol.
    assign w_hit  = r_active[r_rd_q] && (r_sym >= w_rd.lo) && (r_sym <= w_rd.hi);
    assign n_acc  = r_acc | (w_hit ? w_rd.row : '0);
    assign w_last = (r_rd_q == AW'(LIVE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_start     <= '0;
            r_final     <= '0;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START: r_start <= i_cfg_data;
                    CFG_FINAL: r_final <= i_cfg_data[FINAL_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_v <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        case (w_action)
                            ACT_ADVANCE: begin
                                r_sym   <= w_symbol;
                                r_acc   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_SCAN;
                            end
                            ACT_RESTART: begin
                                r_active <= r_start & LIVE_MASK;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_cnt < CNT_W'(LIVE)) begin
                        r_cnt  <= r_cnt + CNT_W'(1);
                        r_rd_v <= 1'b1;
                        r_rd_q <= r_cnt[AW-1:0];
                    end
                    if (r_rd_v) begin
                        if (w_last) begin
                            r_active <= n_acc & LIVE_MASK;
                            r_state  <= S_DONE;
                        end else begin
                            r_acc <= n_acc;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= w_final_ok && r_active[r_final];
                        r_out_stuck <= (r_active == '0);
                        r_out_set   <= r_active;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_set, r_out_stuck, r_out_acc};

    // No state outside the live range ever becomes active.
    a_active_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~LIVE_MASK) == '0)
        else $error("active set holds states beyond the live range");

    // The last table read of a sweep ends the scan.
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_rd_v && w_last) |=> (r_state == S_DONE))
        else $error("scan did not end after the last state");

    // A result is loaded whenever the done state finds the output free.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_m_tvalid && r_out_set == $past(r_active)))
        else $error("result not loaded from the active set");

    // An accepting result never reports an empty set.
    a_acc_not_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("accepting and stuck both set");

endmodule

[dv/nfa_step_checker.sv]
// Scoreboard for position_nfa_set_step: predicts every result from the input stream and compares.
`timescale 1ns / 1ps

module nfa_step_checker
    import pnss_pkg::*;
#(
    parameter int STATE_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // [60:53] label_high, [52:45] label_low, [44:13] row_bits,
    // [12:8] state_index, [7:0] symbol
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [33:2] active_set, [1] is_stuck, [0] accepting
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SET_W-1:0]      i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int LIVE = (STATE_COUNT >= SET_W) ? SET_W : STATE_COUNT;
    localparam logic [SET_W-1:0] LIVE_MASK = {SET_W{1'b1}} >> (SET_W - LIVE);

    // Field order matches the result tdata, lowest bit last.
    typedef struct packed {
        logic [SET_W-1:0] active;
        logic             stuck;
        logic             accepting;
    } t_status;

    logic [SET_W-1:0]   start_set;
    logic [FINAL_W-1:0] final_idx;
    logic [SET_W-1:0]   active_set;
    logic [SET_W-1:0]   follow_row [SET_W];
    logic [SYM_W-1:0]   label_lo [SET_W];
    logic [SYM_W-1:0]   label_hi [SET_W];
    t_status            status_q [$];
    int                 mismatches = 0;

    initial o_pending = 0;
    initial o_fail_count = 0;

    task automatic report_mismatch(string what, logic [SET_W-1:0] got, logic [SET_W-1:0] want);
        mismatches++;
        $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
    endtask

    // Applies one input transaction to the predicted automaton and returns its status.
    function automatic t_status step_nfa(t_action act, logic [IN_DATA_W-1:0] d);
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] idx;
        logic [SET_W-1:0] nxt;
        t_status          st;
        sym = d[7:0];
        idx = d[12:8];
        case (act)
            ACT_ADVANCE: begin
                nxt = '0;
                for (int q = 0; q < LIVE; q++) begin
                    if (active_set[q] && sym >= label_lo[q] && sym <= label_hi[q])
                        nxt |= follow_row[q];
                end
                active_set = nxt & LIVE_MASK;
            end
            ACT_RESTART: active_set = start_set & LIVE_MASK;
            ACT_ROW: begin
                if (idx < LIVE)
                    follow_row[idx] = d[44:13] & LIVE_MASK;
            end
            default: begin
                if (idx < LIVE) begin
                    label_lo[idx] = d[52:45];
                    label_hi[idx] = d[60:53];
                end
            end
        endcase
        st.accepting = (final_idx < LIVE) ? active_set[final_idx] : 1'b0;
        st.stuck     = (active_set == '0);
        st.active    = active_set;
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_status want;
        t_status got;
        if (!i_rst_n) begin
            start_set  = '0;
            final_idx  = '0;
            active_set = '0;
            for (int q = 0; q < SET_W; q++) begin
                follow_row[q] = '0;
                label_lo[q]   = LABEL_LO_RST;
                label_hi[q]   = LABEL_HI_RST;
            end
            status_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[SET_W+1:0];
                if (status_q.size() == 0) begin
                    report_mismatch("result with none expected, active_set", got.active, '0);
                end else begin
                    want = status_q.pop_front();
                    if (got.accepting !== want.accepting)
                        report_mismatch("accepting", SET_W'(got.accepting),
                                        SET_W'(want.accepting));
                    if (got.stuck !== want.stuck)
                        report_mismatch("is_stuck", SET_W'(got.stuck), SET_W'(want.stuck));
                    if (got.active !== want.active)
                        report_mismatch("active_set", got.active, want.active);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START: start_set = i_cfg_data;
                    CFG_FINAL: final_idx = i_cfg_data[FINAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                status_q.push_back(step_nfa(t_action'(i_s_tuser), i_s_tdata));
        end
        o_pending    <= status_q.size();
        o_fail_count <= mismatches;
    end

endmodule

[dv/tb_position_nfa_set_step.sv]
// Testbench top for position_nfa_set_step: stimulus, back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module tb_position_nfa_set_step;
    import pnss_pkg::*;

    localparam int N_STATES    = 32;
    localparam int ITEMS       = 1950;
    localparam int PHASE_ITEMS = 240;
    localparam int LATENCY     = N_STATES + 3;
    localparam int STALL_LIMIT = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SET_W-1:0]      cfg_data = '0;

    int pending;
    int fail_count;
    int items_sent = 0;
    int quiet_cycles = 0;
    int alpha_base = 0;
    bit no_idle = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    position_nfa_set_step #(
        .STATE_COUNT(N_STATES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    nfa_step_checker #(
        .STATE_COUNT(N_STATES)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [SET_W-1:0] rand_set();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return SET_W'(1) << $urandom_range(0, SET_W - 1);
            3: return $urandom;
            default: return $urandom & $urandom;
        endcase
    endfunction

    task automatic send(t_action act, logic [SYM_W-1:0] sym, logic [IDX_W-1:0] idx,
                        logic [SET_W-1:0] row, logic [SYM_W-1:0] lo, logic [SYM_W-1:0] hi);
        int   gap;
        logic took;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, hi, lo, row, idx, sym};
        // ready is stable by the falling edge, so it decides the next rising edge
        do begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic load_config(logic [SET_W-1:0] start_bits, logic [FINAL_W-1:0] fin);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START;
        cfg_data  <= start_bits;
        @(posedge clk);
        cfg_index <= CFG_FINAL;
        cfg_data  <= SET_W'(fin);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Holds the sender off until every transaction has its result back.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_random_label(logic [IDX_W-1:0] idx);
        int lo;
        int hi;
        case ($urandom_range(0, 9))
            0: begin
                lo = $urandom_range(1, 255);
                hi = $urandom_range(0, lo - 1);
            end
            1: begin
                lo = 0;
                hi = 255;
            end
            default: begin
                lo = alpha_base + $urandom_range(0, 7);
                hi = lo + $urandom_range(0, 2);
                if (hi > 255)
                    hi = 255;
            end
        endcase
        send(ACT_LABEL, SYM_W'($urandom), idx, $urandom, SYM_W'(lo), SYM_W'(hi));
    endtask

    // Builds part of a table over a narrow alphabet, then runs restart-and-advance sequences.
    task automatic run_phase(int n);
        int               done_at;
        int               len;
        logic [IDX_W-1:0] idx;
        done_at = items_sent + n;
        repeat ($urandom_range(8, 32)) begin
            idx = IDX_W'($urandom_range(0, 31));
            send(ACT_ROW, SYM_W'($urandom), idx, rand_set(), SYM_W'($urandom),
                 SYM_W'($urandom));
            write_random_label(idx);
        end
        while (items_sent < done_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send(t_action'($urandom_range(0, 3)), SYM_W'($urandom), IDX_W'($urandom),
                     $urandom, SYM_W'($urandom), SYM_W'($urandom));
            end else begin
                send(ACT_RESTART, SYM_W'($urandom), IDX_W'($urandom), $urandom,
                     SYM_W'($urandom), SYM_W'($urandom));
                len = $urandom_range(1, 24);
                repeat (len) begin
                    case ($urandom_range(0, 19))
                        0: send(ACT_ROW, SYM_W'($urandom), IDX_W'($urandom), rand_set(),
                                SYM_W'($urandom), SYM_W'($urandom));
                        1: write_random_label(IDX_W'($urandom_range(0, 31)));
                        2: send(ACT_ADVANCE, SYM_W'($urandom), IDX_W'($urandom), $urandom,
                                SYM_W'($urandom), SYM_W'($urandom));
                        default: send(ACT_ADVANCE, SYM_W'(alpha_base + $urandom_range(0, 7)),
                                      IDX_W'($urandom), $urandom, SYM_W'($urandom),
                                      SYM_W'($urandom));
                    endcase
                end
            end
        end
    endtask

    initial begin : result_sink
        int   stall;
        logic took;
        forever begin
            stall = draw_wait();
            // back-pressure starts once a result is actually waiting
            if (stall > 0) begin
                m_tready <= 1'b0;
                do @(negedge clk); while (!m_tvalid);
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end while (!took);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("** position_nfa_set_step: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int                 ph;
        int                 left;
        logic [SET_W-1:0]   start_pick;
        logic [FINAL_W-1:0] final_pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: empty set, empty labels, start set zero
        send(ACT_ADVANCE, 8'h00, 5'd31, '1, 8'hFF, 8'h00);
        send(ACT_RESTART, 8'hFF, 5'd31, '1, 8'hFF, 8'hFF);
        send(ACT_LABEL, 8'hFF, 5'd0, '1, 8'h00, 8'hFF);
        send(ACT_ROW, 8'hFF, 5'd0, '1, 8'hFF, 8'hFF);

        wait_results();
        load_config('1, 5'd31);
        send(ACT_RESTART, 8'h00, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_LABEL, 8'h00, 5'd31, '0, 8'hFF, 8'hFF);
        send(ACT_LABEL, 8'h00, 5'd5, '0, 8'd200, 8'd100);   // low above high: holds nothing
        send(ACT_LABEL, 8'h00, 5'd1, '0, 8'h00, 8'h00);
        send(ACT_ROW, 8'h00, 5'd31, 32'h8000_0001, 8'h00, 8'h00);
        send(ACT_ROW, 8'h00, 5'd1, 32'h0000_0002, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'hFF, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'h00, 5'd31, '1, 8'hFF, 8'hFF);
        send(ACT_ROW, 8'h00, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'h00, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'h00, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'h07, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'd200, 5'd0, '0, 8'h00, 8'h00);

        wait_results();
        load_config('0, 5'd0);
        send(ACT_RESTART, 8'h00, 5'd0, '0, 8'h00, 8'h00);

        wait_results();
        load_config(32'h0000_0001, 5'd0);
        send(ACT_RESTART, 8'h00, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_ADVANCE, 8'hFF, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_RESTART, 8'h00, 5'd0, '0, 8'h00, 8'h00);
        send(ACT_LABEL, 8'h00, 5'd0, '0, 8'hFF, 8'h00);
        send(ACT_ADVANCE, 8'd128, 5'd0, '0, 8'h00, 8'h00);

        ph = 0;
        while (items_sent < ITEMS) begin
            wait_results();
            case (ph % 4)
                0: begin
                    start_pick = '1;
                    final_pick = 5'd31;
                end
                1: begin
                    start_pick = SET_W'(1) << $urandom_range(0, SET_W - 1);
                    final_pick = 5'd0;
                end
                default: begin
                    start_pick = rand_set() | $urandom;
                    final_pick = FINAL_W'($urandom_range(0, 31));
                end
            endcase
            load_config(start_pick, final_pick);
            no_idle = (ph % 4 == 3);
            case ($urandom_range(0, 3))
                0: alpha_base = 0;
                1: alpha_base = 248;
                default: alpha_base = $urandom_range(0, 248);
            endcase
            left = ITEMS - items_sent;
            run_phase((left < PHASE_ITEMS) ? left : PHASE_ITEMS);
            ph++;
        end

        wait_results();
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** position_nfa_set_step: PASSED **");
        end else begin
            $display("** position_nfa_set_step: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pnss_pkg.sv
hw/rtl/pnss_table.sv
hw/rtl/position_nfa_set_step.sv
dv/nfa_step_checker.sv
dv/tb_position_nfa_set_step.sv
